// ===== rtl/stt_pkg.sv =====
// Package for the software timer table: sizes, command codes, status codes and entry layout.
package stt_pkg;

    localparam int NUM_TIMERS = 16;
    localparam int TIME_BITS  = 48;
    localparam int PERIOD_W   = 32;
    localparam int MASK_W     = 16;
    localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CNT_W      = $clog2(NUM_TIMERS + 1);
    localparam int ENTRY_W    = 1 + PERIOD_W + TIME_BITS;

    localparam int MODE_W   = 3;
    localparam int ID_W     = 4;
    localparam int STATUS_W = 2;
    localparam int NEWID_W  = 4;
    localparam int IN_W     = 88;   // 87 bits of fields, padded to bytes
    localparam int OUT_W    = 120;  // 119 bits of fields, padded to bytes

    typedef enum logic [MODE_W-1:0] {
        MODE_CREATE_ONE = 3'd0,
        MODE_CREATE_REP = 3'd1,
        MODE_STOP       = 3'd2,
        MODE_FIRE       = 3'd3,
        MODE_REFRESH    = 3'd4,
        MODE_REFRESH_AL = 3'd5,
        MODE_QUERY      = 3'd6,
        MODE_UNUSED     = 3'd7
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_BADIDX = 2'd2
    } t_status;

    // Per-entry RAM contents; the active flags live in flops.
    typedef struct packed {
        logic                 reload;
        logic [PERIOD_W-1:0]  period;
        logic [TIME_BITS-1:0] expiry;
    } t_entry;

endpackage

// ===== rtl/stt_ram.sv =====
// Generic simple dual-port RAM with registered read.
module stt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic                                       i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

// ===== rtl/software_timer_table.sv =====
// Software timer table top level: command decode, entry scan over the timer RAM, result beat.
// Flow: the accepting edge starts a scan that reads each allocated slot in turn, passes each
//   entry through stage A (modify) and stage B (write back and accumulate), waits for the
//   pipeline to drain, then registers the result beat; an empty table issues no reads.
// Commands: one at a time; the next beat is taken the cycle after the result is
//   registered, and a stalled result beat holds the block in the done state until it drains.
// Reset (i_rst_n low, synchronous): count and active flags clear, no result pending.
module software_timer_table
    import stt_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    // command channel
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  logic [IN_W-1:0]  i_s_axis_tdata,   // mode[2:0], now[50:3], timer_id[54:51],
                                               // amount[86:55], zero[87]
    // result channel
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    output logic [OUT_W-1:0] o_m_axis_tdata    // status[1:0], new_id[5:2], expired_mask[21:6],
                                               // next_expiry[69:22], none_active[70],
                                               // sleep_ms[118:71], zero[119]
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    // What the scan does to the targeted entry (or all of them)
    typedef enum logic [2:0] {
        OP_QUERY,
        OP_ARM,
        OP_STOP,
        OP_REFRESH,
        OP_REFRESH_ALL
    } t_op;

    localparam logic [TIME_BITS-1:0] TIME_ONES = '1;

    // ---------------- command fields ----------------
    t_mode                in_mode;
    logic [TIME_BITS-1:0] in_now;
    logic [ID_W-1:0]      in_id;
    logic [PERIOD_W-1:0]  in_amount;

    assign in_mode   = t_mode'(i_s_axis_tdata[2:0]);
    assign in_now    = i_s_axis_tdata[50:3];
    assign in_id     = i_s_axis_tdata[54:51];
    assign in_amount = i_s_axis_tdata[86:55];

    // ---------------- registers ----------------
    t_state               r_state;
    logic [CNT_W-1:0]     r_count;
    logic [NUM_TIMERS-1:0] r_active;

    t_op                  r_op;
    logic [IDX_W-1:0]     r_tgt;
    logic                 r_arm_reload;
    logic [PERIOD_W-1:0]  r_amount;
    logic [TIME_BITS-1:0] r_now;
    t_status              r_status;
    logic [NEWID_W-1:0]   r_new_id;
    logic [CNT_W-1:0]     r_limit;

    // scan pointer and two pipeline stages behind the RAM read
    logic [CNT_W-1:0]     r_rd_idx;
    logic                 r_a_vld;
    logic [IDX_W-1:0]     r_a_idx;
    logic                 r_b_vld;
    logic [IDX_W-1:0]     r_b_idx;
    logic                 r_b_wr;
    logic                 r_b_act;
    t_entry               r_b_ent;

    // accumulators
    logic [MASK_W-1:0]    r_mask;
    logic [TIME_BITS-1:0] r_next;
    logic                 r_any;

    logic                 r_out_vld;
    logic [OUT_W-1:0]     r_out_data;

    // ---------------- handshake ----------------
    logic s_acc;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_data;

    // ---------------- timer RAM ----------------
    logic             issue;
    logic             scan_done;
    logic [ENTRY_W-1:0] ram_rdata;

    assign issue     = (r_state == S_SCAN) && (r_rd_idx < r_limit);
    assign scan_done = (r_state == S_SCAN) && !issue && !r_a_vld && !r_b_vld;

    stt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_TIMERS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (r_b_vld && r_b_wr),
        .i_waddr (r_b_idx),
        .i_wdata (r_b_ent),
        .i_re    (issue),
        .i_raddr (r_rd_idx[IDX_W-1:0]),
        .o_rdata (ram_rdata)
    );

    // ---------------- command decode ----------------
    t_op                n_op;
    t_status            n_status;
    logic [NEWID_W-1:0] n_new_id;
    logic [CNT_W-1:0]   n_count;
    logic [IDX_W-1:0]   n_tgt;
    logic               id_bad;

    assign id_bad = (32'(in_id) >= 32'(r_count));

    always_comb begin
        n_op     = OP_QUERY;
        n_status = ST_OK;
        n_new_id = '0;
        n_count  = r_count;
        n_tgt    = IDX_W'(in_id);
        unique case (in_mode)
            MODE_CREATE_ONE, MODE_CREATE_REP: begin
                if (32'(r_count) >= NUM_TIMERS) begin
                    n_status = ST_FULL;
                end else begin
                    n_op     = OP_ARM;
                    n_tgt    = r_count[IDX_W-1:0];
                    n_new_id = NEWID_W'(r_count);
                    n_count  = r_count + CNT_W'(1);
                end
            end
            MODE_STOP, MODE_FIRE, MODE_REFRESH: begin
                if (id_bad) begin
                    n_status = ST_BADIDX;
                end else if (in_mode == MODE_STOP) begin
                    n_op = OP_STOP;
                end else if (in_mode == MODE_FIRE) begin
                    n_op = OP_ARM;
                end else begin
                    n_op = OP_REFRESH;
                end
            end
            MODE_REFRESH_AL: n_op = OP_REFRESH_ALL;
            default:         n_op = OP_QUERY;   // query, and the unused code
        endcase
    end

    // ---------------- stage A: modify the entry just read ----------------
    t_entry               a_ent;
    logic                 a_act;
    logic                 a_hit;
    logic [PERIOD_W-1:0]  a_delay;
    logic [TIME_BITS:0]   a_sum;
    logic [TIME_BITS-1:0] a_sat;
    t_entry               n_b_ent;
    logic                 n_b_act;
    logic                 n_b_wr;

    assign a_ent   = t_entry'(ram_rdata);
    assign a_act   = r_active[r_a_idx];
    assign a_hit   = (r_op == OP_REFRESH_ALL) || ((r_a_idx == r_tgt) && (r_op != OP_QUERY));
    assign a_delay = (r_op == OP_ARM) ? r_amount : a_ent.period;
    assign a_sum   = {1'b0, r_now} + (TIME_BITS + 1)'(a_delay);
    assign a_sat   = a_sum[TIME_BITS] ? TIME_ONES : a_sum[TIME_BITS-1:0];  // saturating add

    always_comb begin
        n_b_ent = a_ent;
        n_b_act = a_act;
        n_b_wr  = 1'b0;
        if (a_hit) begin
            unique case (r_op)
                OP_ARM: begin
                    n_b_ent.reload = r_arm_reload;
                    n_b_ent.period = r_arm_reload ? r_amount : '0;
                    n_b_ent.expiry = a_sat;
                    n_b_act        = 1'b1;
                    n_b_wr         = 1'b1;
                end
                OP_STOP: begin
                    n_b_act = 1'b0;
                    n_b_wr  = 1'b1;
                end
                OP_REFRESH, OP_REFRESH_ALL: begin
                    if (a_act) begin
                        if (a_ent.reload && (a_ent.period != '0)) begin
                            n_b_ent.expiry = a_sat;
                            n_b_wr         = 1'b1;
                        end else if (r_now > a_ent.expiry) begin
                            n_b_act = 1'b0;
                            n_b_wr  = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // ---------------- result ----------------
    logic [TIME_BITS-1:0] n_sleep;
    logic [TIME_BITS-1:0] n_next_out;
    logic [OUT_W-1:0]     n_out_data;

    always_comb begin
        if (!r_any) begin
            n_sleep    = TIME_ONES;
            n_next_out = TIME_ONES;
        end else begin
            n_next_out = r_next;
            n_sleep    = (r_next <= r_now) ? '0 : (r_next - r_now);
        end
        n_out_data = {1'b0, n_sleep, !r_any, n_next_out, r_mask, r_new_id, r_status};
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_active  <= '0;
            r_rd_idx  <= '0;
            r_a_vld   <= 1'b0;
            r_b_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            // the done state reloads the beat itself when it drains
            if (r_out_vld && i_m_axis_tready && (r_state != S_DONE)) begin
                r_out_vld <= 1'b0;
            end

            // pipeline: read -> modify -> write back and accumulate
            r_a_vld <= issue;
            r_a_idx <= r_rd_idx[IDX_W-1:0];
            if (issue) begin
                r_rd_idx <= r_rd_idx + CNT_W'(1);
            end
            r_b_vld <= r_a_vld;
            r_b_idx <= r_a_idx;
            r_b_ent <= n_b_ent;
            r_b_act <= n_b_act;
            r_b_wr  <= n_b_wr;

            if (r_b_vld) begin
                if (r_b_wr) begin
                    r_active[r_b_idx] <= r_b_act;
                end
                for (int k = 0; k < MASK_W; k++) begin
                    if ((int'(r_b_idx) == k) && (r_now >= r_b_ent.expiry)) begin
                        r_mask[k] <= 1'b1;
                    end
                end
                if (r_b_act) begin
                    if (!r_any || (r_b_ent.expiry < r_next)) begin
                        r_next <= r_b_ent.expiry;
                    end
                    r_any <= 1'b1;
                end
            end

            unique case (r_state)
                S_IDLE: begin
                    if (s_acc) begin
                        r_op         <= n_op;
                        r_tgt        <= n_tgt;
                        r_arm_reload <= (in_mode == MODE_CREATE_REP);
                        r_amount     <= in_amount;
                        r_now        <= in_now;
                        r_status     <= n_status;
                        r_new_id     <= n_new_id;
                        r_count      <= n_count;
                        r_limit      <= n_count;
                        r_rd_idx     <= '0;
                        r_mask       <= '0;
                        r_next       <= TIME_ONES;
                        r_any        <= 1'b0;
                        r_state      <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (scan_done) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_vld || i_m_axis_tready) begin
                        r_out_data <= n_out_data;
                        r_out_vld  <= 1'b1;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // ---------------- assertions ----------------
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= NUM_TIMERS)
        else $error("timer count beyond table size");

    a_wr_allocated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_vld && r_b_wr) |-> (32'(r_b_idx) < 32'(r_count)))
        else $error("write back to an unallocated slot");

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!r_a_vld && !r_b_vld))
        else $error("scan pipeline busy while idle");

    a_accept_scans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> (r_state == S_SCAN) && (r_rd_idx == '0))
        else $error("accepted command did not start a scan");

    a_result_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_out_vld && !i_m_axis_tready) |=> (r_state == S_DONE))
        else $error("result overwrote a pending beat");

endmodule

// ===== verif/tb_software_timer_table.sv =====
// Self-checking testbench for the software timer table: command stream in, report beats checked.
`timescale 1ns / 100ps

module tb_software_timer_table;
    import stt_pkg::*;

    localparam logic [TIME_BITS-1:0] TIME_ALL = '1;

    // One report beat, fields in port order (lowest bits last here).
    typedef struct packed {
        logic [TIME_BITS-1:0] sleep_ms;
        logic                 none_active;
        logic [TIME_BITS-1:0] next_expiry;
        logic [MASK_W-1:0]    expired_mask;
        logic [NEWID_W-1:0]   new_id;
        logic [STATUS_W-1:0]  status;
    } t_timer_report;

    // Mirror of the timer table; works out the report for each accepted command
    // and holds the reports still owed by the block.
    class timer_table_scoreboard;
        int                   timer_count;
        bit                   active_flag [NUM_TIMERS];
        bit                   reload_flag [NUM_TIMERS];
        logic [PERIOD_W-1:0]  period_ms   [NUM_TIMERS];
        logic [TIME_BITS-1:0] expiry_at   [NUM_TIMERS];
        t_timer_report        pending_reports[$];
        int                   mismatches;

        function new();
            timer_count = 0;
            mismatches  = 0;
            foreach (active_flag[i]) active_flag[i] = 1'b0;
        endfunction

        // now + delay, clamped at the all-ones time
        function logic [TIME_BITS-1:0] clamp_sum(logic [TIME_BITS-1:0] t,
                                                 logic [PERIOD_W-1:0] d);
            logic [TIME_BITS:0] s;
            s = {1'b0, t} + {{(TIME_BITS + 1 - PERIOD_W){1'b0}}, d};
            if (s > {1'b0, TIME_ALL}) return TIME_ALL;
            return s[TIME_BITS-1:0];
        endfunction

        function void arm_timer(int i, bit reload, logic [PERIOD_W-1:0] period,
                                logic [TIME_BITS-1:0] now, logic [PERIOD_W-1:0] delay);
            active_flag[i] = 1'b1;
            reload_flag[i] = reload;
            period_ms[i]   = period;
            expiry_at[i]   = clamp_sum(now, delay);
        endfunction

        function void refresh_timer(int i, logic [TIME_BITS-1:0] now);
            if (!active_flag[i]) return;
            if (reload_flag[i] && period_ms[i] != '0)
                expiry_at[i] = clamp_sum(now, period_ms[i]);
            else if (now > expiry_at[i])
                active_flag[i] = 1'b0;
        endfunction

        function void note_command(t_mode mode, logic [TIME_BITS-1:0] now,
                                   logic [ID_W-1:0] id, logic [PERIOD_W-1:0] amount);
            t_timer_report rpt;
            bit            any_active;
            rpt = '0;
            rpt.status = ST_OK;
            case (mode)
                MODE_CREATE_ONE, MODE_CREATE_REP: begin
                    if (timer_count >= NUM_TIMERS) begin
                        rpt.status = ST_FULL;
                    end else begin
                        if (mode == MODE_CREATE_ONE)
                            arm_timer(timer_count, 1'b0, '0, now, amount);
                        else
                            arm_timer(timer_count, 1'b1, amount, now, amount);
                        rpt.new_id  = timer_count[NEWID_W-1:0];
                        timer_count = timer_count + 1;
                    end
                end
                MODE_STOP, MODE_FIRE, MODE_REFRESH: begin
                    if (int'(id) >= timer_count) begin
                        rpt.status = ST_BADIDX;     // bad index leaves the table alone
                    end else if (mode == MODE_STOP) begin
                        active_flag[id] = 1'b0;     // expiry kept on purpose
                    end else if (mode == MODE_FIRE) begin
                        arm_timer(int'(id), 1'b0, '0, now, amount);
                    end else begin
                        refresh_timer(int'(id), now);
                    end
                end
                MODE_REFRESH_AL: begin
                    for (int i = 0; i < timer_count; i++) refresh_timer(i, now);
                end
                default: ;                          // query and the spare code
            endcase

            // scan: expired mask over allocated slots, earliest active expiry
            any_active      = 1'b0;
            rpt.next_expiry = TIME_ALL;
            for (int i = 0; i < timer_count; i++) begin
                if (i < MASK_W && now >= expiry_at[i]) rpt.expired_mask[i] = 1'b1;
                if (active_flag[i]) begin
                    if (!any_active || expiry_at[i] < rpt.next_expiry)
                        rpt.next_expiry = expiry_at[i];
                    any_active = 1'b1;
                end
            end
            rpt.none_active = !any_active;
            if (!any_active) begin
                rpt.next_expiry = TIME_ALL;
                rpt.sleep_ms    = TIME_ALL;
            end else if (rpt.next_expiry <= now) begin
                rpt.sleep_ms    = '0;
            end else begin
                rpt.sleep_ms    = rpt.next_expiry - now;
            end
            pending_reports.insert(pending_reports.size(), rpt);
        endfunction

        function void check_report(logic [OUT_W-1:0] beat);
            t_timer_report got, exp;
            got = t_timer_report'(beat[$bits(t_timer_report)-1:0]);
            if (pending_reports.size() == 0) begin
                $error("report beat with nothing outstanding: %h", beat);
                mismatches++;
                return;
            end
            exp = pending_reports.pop_front();
            if (got.status !== exp.status) begin
                $error("status: expected %0d, got %0d", exp.status, got.status);
                mismatches++;
            end
            if (got.new_id !== exp.new_id) begin
                $error("new_id: expected %0d, got %0d", exp.new_id, got.new_id);
                mismatches++;
            end
            if (got.expired_mask !== exp.expired_mask) begin
                $error("expired_mask: expected %h, got %h", exp.expired_mask, got.expired_mask);
                mismatches++;
            end
            if (got.next_expiry !== exp.next_expiry) begin
                $error("next_expiry: expected %h, got %h", exp.next_expiry, got.next_expiry);
                mismatches++;
            end
            if (got.none_active !== exp.none_active) begin
                $error("none_active: expected %0d, got %0d", exp.none_active, got.none_active);
                mismatches++;
            end
            if (got.sleep_ms !== exp.sleep_ms) begin
                $error("sleep_ms: expected %h, got %h", exp.sleep_ms, got.sleep_ms);
                mismatches++;
            end
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n         = 1'b0;
    logic             i_s_axis_tvalid = 1'b0;
    logic             o_s_axis_tready;
    logic [IN_W-1:0]  i_s_axis_tdata  = '0;   // mode, now, timer_id, amount, zero pad
    logic             o_m_axis_tvalid;
    logic             i_m_axis_tready = 1'b0;
    logic [OUT_W-1:0] o_m_axis_tdata;         // status, new_id, expired_mask, next_expiry,
                                              // none_active, sleep_ms, zero pad

    timer_table_scoreboard timer_sb = new();

    int burst_left = 0;   // beats left in the current sender burst

    software_timer_table dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Result side: stretches of steady ready, steady stall, and per-cycle coin flips.
    initial begin : ready_pattern
        int style;
        int stretch;
        forever begin
            style   = $urandom_range(0, 3);
            stretch = (style == 1) ? $urandom_range(1, 6) : $urandom_range(1, 20);
            repeat (stretch) begin
                @(posedge i_clk);
                case (style)
                    0:       i_m_axis_tready <= 1'b1;
                    1:       i_m_axis_tready <= 1'b0;
                    default: i_m_axis_tready <= 1'($urandom_range(0, 1));
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            timer_sb.check_report(o_m_axis_tdata);
    end

    // Drive one command beat, wait for it to be taken, then maybe drop into a gap.
    // Valid stays high across back-to-back beats within a burst.
    task automatic issue_cmd(t_mode mode, logic [TIME_BITS-1:0] now,
                             logic [ID_W-1:0] id, logic [PERIOD_W-1:0] amount);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {1'b0, amount, id, now, mode};
        do @(posedge i_clk); while (!o_s_axis_tready);
        timer_sb.note_command(mode, now, id, amount);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 9);
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    initial begin : stimulus
        logic [TIME_BITS-1:0] clock_ms;
        logic [TIME_BITS-1:0] now;
        logic [63:0]          wide;
        logic [ID_W-1:0]      id;
        logic [PERIOD_W-1:0]  amount;
        t_mode                mode;
        int                   pick;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed: empty table, each command, expiry edges, saturation, spare code
        issue_cmd(MODE_QUERY,      48'd0,    4'd0,  32'd0);
        issue_cmd(MODE_STOP,       48'd5,    4'd0,  32'd0);      // nothing allocated yet
        issue_cmd(MODE_CREATE_ONE, 48'd1000, 4'd0,  32'd50);
        issue_cmd(MODE_CREATE_REP, 48'd1000, 4'd0,  32'd100);
        issue_cmd(MODE_CREATE_REP, 48'd1010, 4'd0,  32'd0);      // repeating, zero period
        issue_cmd(MODE_QUERY,      48'd1050, 4'd0,  32'd0);      // timer 0 exactly due
        issue_cmd(MODE_REFRESH,    48'd1050, 4'd0,  32'd0);      // not past yet: stays
        issue_cmd(MODE_REFRESH,    48'd1051, 4'd0,  32'd0);      // now past: drops
        issue_cmd(MODE_REFRESH_AL, 48'd1060, 4'd0,  32'd0);
        issue_cmd(MODE_STOP,       48'd1070, 4'd1,  32'd0);
        issue_cmd(MODE_FIRE,       48'd1070, 4'd1,  32'd0);      // due at once, sleep 0
        issue_cmd(MODE_FIRE,       48'd1080, 4'd15, 32'd7);      // bad index
        issue_cmd(MODE_REFRESH,    48'd1080, 4'd9,  32'd0);      // bad index
        issue_cmd(MODE_UNUSED,     48'd1080, 4'd3,  32'd9);
        issue_cmd(MODE_CREATE_ONE, TIME_ALL, 4'd0,  32'd0);      // start at max time
        issue_cmd(MODE_CREATE_REP, TIME_ALL - 48'd5, 4'd0, '1);  // sum clamps
        issue_cmd(MODE_FIRE,       48'd0,    4'd0,  '1);
        issue_cmd(MODE_QUERY,      TIME_ALL, 4'd0,  32'd0);      // everything due
        issue_cmd(MODE_REFRESH_AL, TIME_ALL, 4'd0,  32'd0);
        issue_cmd(MODE_QUERY,      48'd0,    4'd0,  32'd0);

        // --- random: mostly a steadily advancing clock, with wild times mixed in
        wide     = {$urandom(), $urandom()};
        clock_ms = {8'd0, wide[39:0]};
        repeat (700) begin
            pick = $urandom_range(0, 99);
            if      (pick < 10) mode = MODE_CREATE_ONE;
            else if (pick < 18) mode = MODE_CREATE_REP;
            else if (pick < 30) mode = MODE_STOP;
            else if (pick < 45) mode = MODE_FIRE;
            else if (pick < 60) mode = MODE_REFRESH;
            else if (pick < 75) mode = MODE_REFRESH_AL;
            else if (pick < 96) mode = MODE_QUERY;
            else                mode = MODE_UNUSED;

            pick = $urandom_range(0, 99);
            if (pick < 85) begin
                clock_ms = clock_ms + 48'($urandom_range(0, 60));
                now      = clock_ms;
            end else if (pick < 93) begin
                wide = {$urandom(), $urandom()};
                now  = wide[TIME_BITS-1:0];
            end else if (pick < 97) begin
                now = TIME_ALL - 48'($urandom_range(0, 50));
            end else begin
                now = 48'($urandom_range(0, 100));
            end

            if (timer_sb.timer_count > 0 && $urandom_range(0, 99) < 80)
                id = ID_W'($urandom_range(0, timer_sb.timer_count - 1));
            else
                id = ID_W'($urandom_range(0, 15));

            pick = $urandom_range(0, 99);
            if      (pick < 60) amount = $urandom_range(0, 150);
            else if (pick < 75) amount = '0;
            else if (pick < 90) amount = $urandom();
            else                amount = '1 - PERIOD_W'($urandom_range(0, 20));

            issue_cmd(mode, now, id, amount);
        end
        i_s_axis_tvalid <= 1'b0;

        while (timer_sb.pending_reports.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        if (timer_sb.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/stt_pkg.sv
rtl/stt_ram.sv
rtl/software_timer_table.sv
verif/tb_software_timer_table.sv
